// ===== hdl/paged_list_allocator_core_macros.svh =====
// Assertion macros for the paged list allocator.
// Used by the port checker; no other dependencies.
`ifndef PAGED_LIST_ALLOCATOR_CORE_MACROS_SVH
`define PAGED_LIST_ALLOCATOR_CORE_MACROS_SVH
`define PLA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define PLA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== hdl/pla_pkg.sv =====
// Shared types and constants for the paged list allocator.
// No dependencies.
package pla_pkg;
    localparam int PAGE_ELEMS  = 16;
    localparam int NUM_PAGES   = 256;
    localparam int SCOPE_DEPTH = 16;
    localparam int PW  = $clog2(NUM_PAGES);
    localparam int EW  = $clog2(PAGE_ELEMS);
    localparam int SW  = $clog2(SCOPE_DEPTH);
    localparam int AW  = PW + EW;
    localparam int STORE_SIZE = NUM_PAGES * PAGE_ELEMS;

    typedef enum logic [2:0] {
        CMD_CREATE = 3'd0, CMD_ASSIGN = 3'd1, CMD_READ = 3'd2,
        CMD_FREE_LIST = 3'd3, CMD_FREE_SCOPE = 3'd4, CMD_ENTER = 3'd5,
        CMD_NOP6 = 3'd6, CMD_NOP7 = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_NOSPACE = 2'd1, ST_OOB = 2'd2, ST_NOSCOPE = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DISPATCH, S_COUNT, S_CHECK, S_ALLOC, S_ALLOC_DONE,
        S_WALK, S_ACCESS, S_RDWAIT, S_FREE, S_SWEEP, S_DONE
    } state_t;

    typedef struct packed {
        logic start;       // latch the command beat
        logic cnt_clear;   // reset sweep pointer and counters
        logic cnt_step;    // count one page
        logic alloc_step;  // take one page for create
        logic alloc_fin;   // mark head, update peak
        logic walk_step;   // follow one chain link
        logic wr_elem;
        logic rd_elem;
        logic free_step;   // release one chain page
        logic sweep_step;  // release page of innermost scope
        logic scope_push;
        logic scope_pop;
        logic set_status;
        status_t status;
    } ctl_t;

    typedef struct packed {
        cmd_t cmd;
        logic scope_zero;
        logic scope_full;
        logic cnt_last;     // sweep pointer at last page of range
        logic cap_ok;
        logic alloc_done;
        logic head_ok;
        logic walk_done;
        logic walk_bad;
        logic pos_ok;
        logic free_done;
    } sts_t;
endpackage

// ===== hdl/pla_ctrl.sv =====
// Controller for the paged list allocator.
// Depends on pla_pkg.
module pla_ctrl
    import pla_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_go,
    input  logic out_busy,
    input  sts_t sts,
    output ctl_t ctl,
    output logic idle,
    output logic done
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (in_go) state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                unique case (sts.cmd)
                    CMD_CREATE:     state_next = sts.scope_zero ? S_DONE : S_COUNT;
                    CMD_ASSIGN,
                    CMD_READ:       state_next = sts.head_ok ? S_WALK : S_DONE;
                    CMD_FREE_LIST:  state_next = sts.head_ok ? S_FREE : S_DONE;
                    CMD_FREE_SCOPE: state_next = sts.scope_zero ? S_DONE : S_SWEEP;
                    default:        state_next = S_DONE;
                endcase
            end
            S_COUNT:    if (sts.cnt_last) state_next = S_CHECK;
            S_CHECK:    state_next = sts.cap_ok ? S_ALLOC : S_DONE;
            S_ALLOC:    if (sts.alloc_done) state_next = S_ALLOC_DONE;
            S_ALLOC_DONE: state_next = S_DONE;
            S_WALK:
            begin
                if (sts.walk_bad) state_next = S_DONE;
                else if (sts.walk_done) state_next = S_ACCESS;
            end
            S_ACCESS:
            begin
                if (!sts.pos_ok) state_next = S_DONE;
                else if (sts.cmd == CMD_READ) state_next = S_RDWAIT;
                else state_next = S_DONE;
            end
            S_RDWAIT:   state_next = S_DONE;
            S_FREE:     if (sts.free_done) state_next = S_DONE;
            S_SWEEP:    if (sts.cnt_last) state_next = S_DONE;
            S_DONE:     if (!out_busy) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl = '0;
        ctl.status = ST_OK;
        idle = (state_reg == S_IDLE);
        done = 1'b0;
        unique case (state_reg)
            S_IDLE:     ctl.start = in_go;
            S_DISPATCH:
            begin
                ctl.cnt_clear = 1'b1;
                unique case (sts.cmd)
                    CMD_CREATE:
                        if (sts.scope_zero)
                        begin
                            ctl.set_status = 1'b1;
                            ctl.status = ST_NOSCOPE;
                        end
                    CMD_ASSIGN, CMD_READ, CMD_FREE_LIST:
                        if (!sts.head_ok)
                        begin
                            ctl.set_status = 1'b1;
                            ctl.status = ST_OOB;
                        end
                    CMD_FREE_SCOPE:
                        if (sts.scope_zero)
                        begin
                            ctl.set_status = 1'b1;
                            ctl.status = ST_NOSCOPE;
                        end
                    CMD_ENTER:
                    begin
                        if (sts.scope_full)
                        begin
                            ctl.set_status = 1'b1;
                            ctl.status = ST_NOSPACE;
                        end
                        else
                            ctl.scope_push = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_COUNT:    ctl.cnt_step = 1'b1;
            S_CHECK:
            begin
                ctl.cnt_clear = 1'b1;
                if (!sts.cap_ok)
                begin
                    ctl.set_status = 1'b1;
                    ctl.status = ST_NOSPACE;
                end
            end
            S_ALLOC:    ctl.alloc_step = 1'b1;
            S_ALLOC_DONE: ctl.alloc_fin = 1'b1;
            S_WALK:
            begin
                ctl.walk_step = 1'b1;
                if (sts.walk_bad)
                begin
                    ctl.set_status = 1'b1;
                    ctl.status = ST_OOB;
                end
            end
            S_ACCESS:
            begin
                if (!sts.pos_ok)
                begin
                    ctl.set_status = 1'b1;
                    ctl.status = ST_OOB;
                end
                else if (sts.cmd == CMD_READ)
                    ctl.rd_elem = 1'b1;
                else
                    ctl.wr_elem = 1'b1;
            end
            S_RDWAIT:   ;
            S_FREE:     ctl.free_step = 1'b1;
            S_SWEEP:
            begin
                ctl.sweep_step = 1'b1;
                ctl.scope_pop = sts.cnt_last;
            end
            S_DONE:     done = !out_busy;
            default:    ;
        endcase
    end
endmodule

// ===== hdl/pla_dpath.sv =====
// Datapath for the paged list allocator: page map, element store, counters.
// Depends on pla_pkg.
module pla_dpath
    import pla_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ctl_t                ctl,
    input  logic                cfg_we,
    input  logic [12:0]         cfg_data,
    input  logic [2:0]          cmd_in,
    input  logic [7:0]          handle_in,
    input  logic [11:0]         offset_in,
    input  logic [12:0]         length_in,
    input  logic signed [31:0]  value_in,
    output sts_t                sts,
    output status_t             res_status,
    output logic [7:0]          res_handle,
    output logic signed [31:0]  res_read,
    output logic [8:0]          res_peak
);
    localparam int CW = PW + 1;

    logic [NUM_PAGES-1:0] free_reg;
    logic [NUM_PAGES-1:0] head_reg;
    logic [PW:0]          next_mem [NUM_PAGES];
    logic [EW:0]          fill_mem [NUM_PAGES];
    logic [SW-1:0]        owner_mem [NUM_PAGES];
    logic [31:0]          store_mem [STORE_SIZE];

    logic [12:0]   total_reg;
    logic [SW:0]   scope_reg;
    logic [8:0]    peak_reg;
    logic [CW-1:0] inuse_reg;

    cmd_t          cmd_reg;
    logic [PW-1:0] handle_reg;
    logic [11:0]   offset_reg;
    logic [12:0]   length_reg;
    logic [31:0]   value_reg;

    logic [CW-1:0] ptr_reg;      // sweep pointer, up to NUM_PAGES
    logic [CW-1:0] fcnt_reg;
    logic [12:0]   rem_reg;
    logic [PW:0]   prev_reg;
    logic [PW-1:0] first_reg;
    logic [PW:0]   cur_reg;
    logic [11:0]   hops_reg;
    logic [CW-1:0] fsteps_reg;

    status_t       st_reg;
    logic [7:0]    nh_reg;
    logic [31:0]   rd_reg;

    logic [PW:0]   next_q;
    logic [EW:0]   fill_q;
    logic [SW-1:0] owner_q;

    logic [12:0]   tot_clamp;
    logic [CW-1:0] usable;
    logic [EW-1:0] tot_low;
    logic [12:0]   tail;
    logic [CW+EW-1:0] cap;
    logic [PW-1:0] ptr_idx;
    logic [PW-1:0] cur_idx;
    logic [EW-1:0] pos;
    logic [12:0]   take_n;
    logic [PW-1:0] rd_addr;
    logic [PW-1:0] own_addr;

    assign tot_clamp = (total_reg > 13'(STORE_SIZE)) ? 13'(STORE_SIZE) : total_reg;
    assign tot_low   = tot_clamp[EW-1:0];
    assign usable    = CW'((tot_clamp + 13'(PAGE_ELEMS - 1)) >> EW);
    assign ptr_idx   = ptr_reg[PW-1:0];
    assign cur_idx   = cur_reg[PW-1:0];
    assign pos       = offset_reg[EW-1:0];
    assign tail = (usable != '0 && free_reg[PW'(usable - 1'b1)] && tot_low != '0)
                ? 13'(PAGE_ELEMS) - 13'(tot_low) : 13'd0;
    assign cap  = (CW+EW)'({fcnt_reg, {EW{1'b0}}}) - (CW+EW)'(tail);
    assign take_n = (rem_reg < 13'(PAGE_ELEMS)) ? rem_reg : 13'(PAGE_ELEMS);

    assign rd_addr  = ctl.cnt_clear ? handle_reg
                    : (((ctl.walk_step && hops_reg != '0) || (ctl.free_step && !sts.free_done))
                       ? next_q[PW-1:0] : cur_idx);
    assign own_addr = ctl.cnt_clear ? '0 : (ctl.sweep_step ? PW'(ptr_idx + 1'b1) : ptr_idx);

    always_comb
    begin
        sts.cmd        = cmd_reg;
        sts.scope_zero = (scope_reg == '0);
        sts.scope_full = (scope_reg >= (SW+1)'(SCOPE_DEPTH));
        sts.cnt_last   = (cmd_reg == CMD_CREATE)
                       ? (ptr_reg + 1'b1 >= usable) : (ptr_reg == CW'(NUM_PAGES - 1));
        sts.cap_ok     = (length_reg != '0) && ((CW+EW)'(length_reg) <= cap)
                       && (usable != '0);
        sts.alloc_done = (rem_reg == '0);
        sts.head_ok    = !free_reg[handle_reg] && head_reg[handle_reg];
        sts.walk_done  = (hops_reg == '0);
        sts.walk_bad   = (hops_reg != '0) && (next_q >= (PW+1)'(NUM_PAGES)
                       || free_reg[next_q[PW-1:0]]);
        sts.pos_ok     = ((EW+1)'(pos) < fill_q);
        sts.free_done  = (cur_reg >= (PW+1)'(NUM_PAGES)) || free_reg[cur_idx]
                       || (fsteps_reg == CW'(NUM_PAGES));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= 13'd4096;
            free_reg  <= '1;
            head_reg  <= '0;
            scope_reg <= '0;
            peak_reg  <= '0;
            inuse_reg <= '0;
            cmd_reg   <= CMD_NOP6;
        end
        else
        begin
            if (cfg_we)
                total_reg <= cfg_data;
            if (ctl.start)
                cmd_reg <= cmd_t'(cmd_in);
            if (ctl.scope_push)
                scope_reg <= scope_reg + 1'b1;
            if (ctl.scope_pop)
                scope_reg <= scope_reg - 1'b1;
            if (ctl.alloc_step && rem_reg != '0 && free_reg[ptr_idx])
            begin
                free_reg[ptr_idx] <= 1'b0;
                head_reg[ptr_idx] <= 1'b0;
                inuse_reg <= inuse_reg + 1'b1;
            end
            if (ctl.alloc_fin)
            begin
                head_reg[first_reg] <= 1'b1;
                if (9'(inuse_reg) > peak_reg)
                    peak_reg <= 9'(inuse_reg);
            end
            if (ctl.free_step && !sts.free_done)
            begin
                free_reg[cur_idx] <= 1'b1;
                head_reg[cur_idx] <= 1'b0;
                inuse_reg <= inuse_reg - 1'b1;
            end
            if (ctl.sweep_step && !free_reg[ptr_idx]
                && owner_q == SW'(scope_reg - 1'b1))
            begin
                free_reg[ptr_idx] <= 1'b1;
                head_reg[ptr_idx] <= 1'b0;
                inuse_reg <= inuse_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        next_q  <= next_mem[rd_addr];
        fill_q  <= fill_mem[rd_addr];
        owner_q <= owner_mem[own_addr];
        if (ctl.start)
        begin
            handle_reg <= handle_in;
            offset_reg <= offset_in;
            length_reg <= length_in;
            value_reg  <= value_in;
            st_reg     <= ST_OK;
            nh_reg     <= '0;
            rd_reg     <= '0;
        end
        if (ctl.set_status)
            st_reg <= ctl.status;
        if (ctl.cnt_clear)
        begin
            ptr_reg    <= '0;
            fcnt_reg   <= '0;
            rem_reg    <= length_reg;
            prev_reg   <= (PW+1)'(NUM_PAGES);
            cur_reg    <= {1'b0, handle_reg};
            hops_reg   <= offset_reg >> EW;
            fsteps_reg <= '0;
        end
        if (ctl.cnt_step)
        begin
            ptr_reg  <= ptr_reg + 1'b1;
            fcnt_reg <= fcnt_reg + CW'(free_reg[ptr_idx]);
        end
        if (ctl.sweep_step)
            ptr_reg <= ptr_reg + 1'b1;
        if (ctl.alloc_step && rem_reg != '0)
        begin
            ptr_reg <= ptr_reg + 1'b1;
            if (free_reg[ptr_idx])
            begin
                fill_mem[ptr_idx]  <= (EW+1)'(take_n);
                owner_mem[ptr_idx] <= SW'(scope_reg - 1'b1);
                if (prev_reg == (PW+1)'(NUM_PAGES))
                    first_reg <= ptr_idx;
                else
                    next_mem[prev_reg[PW-1:0]] <= {1'b0, ptr_idx};
                prev_reg <= {1'b0, ptr_idx};
                rem_reg  <= rem_reg - take_n;
            end
        end
        if (ctl.alloc_fin)
        begin
            nh_reg <= 8'(first_reg);
            next_mem[prev_reg[PW-1:0]] <= (PW+1)'(NUM_PAGES);
        end
        if (ctl.walk_step && hops_reg != '0)
        begin
            cur_reg  <= next_q;
            hops_reg <= hops_reg - 1'b1;
        end
        if (ctl.free_step && !sts.free_done)
        begin
            cur_reg    <= next_q;
            fsteps_reg <= fsteps_reg + 1'b1;
        end
        if (ctl.wr_elem)
            store_mem[{cur_idx, pos}] <= value_reg;
        if (ctl.rd_elem)
            rd_reg <= store_mem[{cur_idx, pos}];
    end

    assign res_status = st_reg;
    assign res_handle = nh_reg;
    assign res_read   = rd_reg;
    assign res_peak   = peak_reg;
endmodule

// ===== hdl/paged_list_allocator_core.sv =====
// Paged list allocator: one command in, one result beat out.
// Create counts the free pages and then allocates; assign and read walk the chain;
// free list follows the chain; free scope sweeps every page. One command at a time:
// each finishes before the next is taken. The next command is accepted while the result
// waits. Reset (rst_n, asynchronous): all pages free, no scopes, peak zero.
module paged_list_allocator_core
    import pla_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         command,
    input  logic [7:0]         list_handle,
    input  logic [11:0]        offset,
    input  logic [12:0]        length,
    input  logic signed [31:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [7:0]         new_handle,
    output logic signed [31:0] read_value,
    output logic [8:0]         peak_pages,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [12:0]        cfg_data
);
    ctl_t    ctl;
    sts_t    sts;
    logic    idle, done;
    status_t r_status;
    logic [7:0]  r_handle;
    logic signed [31:0] r_read;
    logic [8:0]  r_peak;
    logic out_valid_reg;

    assign in_ready  = idle;
    assign cfg_ready = 1'b1;

    pla_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_go(in_valid & idle),
        .out_busy(out_valid_reg & ~out_ready),
        .sts(sts), .ctl(ctl), .idle(idle), .done(done)
    );

    pla_dpath u_dpath (
        .clk(clk), .rst_n(rst_n), .ctl(ctl),
        .cfg_we(cfg_valid), .cfg_data(cfg_data),
        .cmd_in(command), .handle_in(list_handle), .offset_in(offset),
        .length_in(length), .value_in(value), .sts(sts),
        .res_status(r_status), .res_handle(r_handle),
        .res_read(r_read), .res_peak(r_peak)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            status     <= r_status;
            new_handle <= r_handle;
            read_value <= r_read;
            peak_pages <= r_peak;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

// ===== hdl/pla_checker.sv =====
// Port checker for the paged list allocator core.
// Depends on paged_list_allocator_core_macros.svh.
`include "paged_list_allocator_core_macros.svh"
module pla_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic [7:0] new_handle,
    input logic [8:0] peak_pages
);
    `PLA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
    `PLA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(status))
    `PLA_ASSERT_IMPL(a_handle_ok, clk, rst_n, out_valid && status != 2'd0, new_handle == 8'd0)
    `PLA_ASSERT_NEXT(a_peak_mono, clk, rst_n, out_valid && out_ready, !out_valid || peak_pages >= $past(peak_pages))
endmodule

bind paged_list_allocator_core pla_checker u_pla_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .new_handle(new_handle), .peak_pages(peak_pages)
);
